// ===== rtl/csi_escape_sequence_parser_assert.svh =====
// Assertion macros used by the parser RTL.
`ifndef CSI_ESCAPE_SEQUENCE_PARSER_ASSERT_SVH
`define CSI_ESCAPE_SEQUENCE_PARSER_ASSERT_SVH

// Same-cycle implication on aclk, off while in reset.
`define CSIESP_ASSERT_SAME(label, ante, cons, msg) \
    label: assert property (@(posedge aclk) disable iff (!aresetn) (ante) |-> (cons)) \
        else $error(msg);

// Next-cycle implication on aclk, off while in reset.
`define CSIESP_ASSERT_NEXT(label, ante, cons, msg) \
    label: assert property (@(posedge aclk) disable iff (!aresetn) (ante) |=> (cons)) \
        else $error(msg);

`endif

// ===== rtl/csiesp_pkg.sv =====
`default_nettype none

package csiesp_pkg;

    typedef struct packed {
        logic [7:0]  data_byte;
        logic        last_byte;
        logic [15:0] base_position;
    } in_beat_t;

    typedef struct packed {
        logic [1:0]  status;
        logic [7:0]  command_byte;
        logic [15:0] mode_value;
        logic        mode_present;
        logic [15:0] start_position;
        logic [15:0] end_position;
        logic        erase_request;
    } out_beat_t;

    typedef enum logic [3:0] {
        PH_ESC     = 4'b0001,
        PH_BRACKET = 4'b0010,
        PH_PARAMS  = 4'b0100,
        PH_SKIP    = 4'b1000
    } phase_t;

    localparam logic [1:0] ST_COMPLETE   = 2'd0;
    localparam logic [1:0] ST_INCOMPLETE = 2'd1;
    localparam logic [1:0] ST_NOT_CSI    = 2'd2;

    localparam logic [7:0] CH_ESC      = 8'h1B;
    localparam logic [7:0] CH_BRACKET  = 8'h5B;
    localparam logic [7:0] CH_SEMI     = 8'h3B;
    localparam logic [7:0] CH_COLON    = 8'h3A;
    localparam logic [7:0] CH_NUL      = 8'h00;
    localparam logic [7:0] CH_ZERO     = 8'h30;
    localparam logic [7:0] CH_NINE     = 8'h39;
    localparam logic [7:0] CH_ERASE_K  = 8'h4B;
    localparam logic [7:0] CH_ERASE_J  = 8'h4A;
    localparam logic [7:0] FINAL_LO    = 8'h40;
    localparam logic [7:0] FINAL_HI    = 8'h7E;

    localparam logic [15:0] MODE_MAX   = 16'hFFFF;

endpackage

`default_nettype wire

// ===== rtl/csiesp_skid.sv =====
`default_nettype none

module csiesp_skid
    import csiesp_pkg::*;
(
    input  wire logic     aclk,
    input  wire logic     aresetn,
    input  wire logic     in_valid,
    output logic          in_ready,
    input  wire in_beat_t in_beat,
    output logic          out_valid,
    input  wire logic     out_ready,
    output in_beat_t      out_beat
);

    logic     main_valid_reg;
    logic     spare_valid_reg;
    in_beat_t main_reg;
    in_beat_t spare_reg;
    logic     in_fire;
    logic     drain;

    assign in_ready  = !spare_valid_reg;
    assign in_fire   = in_valid && !spare_valid_reg;
    assign drain     = out_ready || !main_valid_reg;
    assign out_valid = main_valid_reg;
    assign out_beat  = main_reg;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            main_valid_reg  <= 1'b0;
            spare_valid_reg <= 1'b0;
        end else if (drain) begin
            if (spare_valid_reg) begin
                main_valid_reg  <= 1'b1;
                spare_valid_reg <= 1'b0;
            end else begin
                main_valid_reg <= in_fire;
            end
        end else if (in_fire) begin
            spare_valid_reg <= 1'b1;
        end
    end

    always_ff @(posedge aclk) begin
        if (drain) begin
            if (spare_valid_reg) begin
                main_reg <= spare_reg;
            end else if (in_fire) begin
                main_reg <= in_beat;
            end
        end else if (in_fire) begin
            spare_reg <= in_beat;
        end
    end

endmodule

`default_nettype wire

// ===== rtl/csi_escape_sequence_parser.sv =====
// Results are registered: m_valid rises in the cycle after the parser takes the beat that completes it.
// Throughput: one input beat per cycle while m_ready is high; one x10 parse update per cycle.
// A held result stalls the parser; s_ready is registered and drops once the skid stage is full.
// Reset: aresetn is synchronous and active low; it empties both stages and
// rearms the parser to expect an escape byte at the start of a new buffer.
`default_nettype none
`include "csi_escape_sequence_parser_assert.svh"

module csi_escape_sequence_parser
    import csiesp_pkg::*;
#(
    parameter int POSITION_WIDTH = 16
) (
    input  wire logic      aclk,
    input  wire logic      aresetn,
    input  wire logic      s_valid,
    output logic           s_ready,
    input  wire in_beat_t  s_beat,
    output logic           m_valid,
    input  wire logic      m_ready,
    output out_beat_t      m_beat
);

    localparam int EXT_W = POSITION_WIDTH + 16;

    logic     core_valid;
    logic     core_ready;
    in_beat_t core_beat;
    logic     core_fire;

    csiesp_skid u_skid (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .in_valid  (s_valid),
        .in_ready  (s_ready),
        .in_beat   (s_beat),
        .out_valid (core_valid),
        .out_ready (core_ready),
        .out_beat  (core_beat)
    );

    phase_t                    phase_reg, phase_next;
    logic                      escape_ok_reg, escape_ok_next;
    logic [15:0]               acc_reg, acc_next;
    logic                      closed_reg, closed_next;
    logic                      bad_reg, bad_next;
    logic [POSITION_WIDTH-1:0] offset_reg, offset_next;
    logic [POSITION_WIDTH-1:0] start_reg, start_next;
    logic                      m_valid_reg;
    out_beat_t                 m_beat_reg;
    logic                      res_valid;
    out_beat_t                 res_beat;

    logic [7:0]                b;
    logic [EXT_W-1:0]          base_ext;
    logic [EXT_W-1:0]          start_ext;
    logic [EXT_W-1:0]          end_ext;
    logic [POSITION_WIDTH-1:0] end_pos;
    logic [19:0]               acc_sum;
    logic                      present;

    assign core_ready = !m_valid_reg || m_ready;
    assign core_fire  = core_valid && core_ready;
    assign m_valid    = m_valid_reg;
    assign m_beat     = m_beat_reg;

    assign b         = core_beat.data_byte;
    assign base_ext  = EXT_W'(core_beat.base_position);
    assign start_ext = EXT_W'(start_reg);
    assign end_pos   = start_reg + offset_reg + POSITION_WIDTH'(1);
    assign end_ext   = EXT_W'(end_pos);
    assign acc_sum   = {1'b0, acc_reg, 3'b000} + {3'b000, acc_reg, 1'b0}
                     + 20'(b - CH_ZERO);
    assign present   = !bad_reg;

    always_comb begin
        phase_next     = phase_reg;
        escape_ok_next = escape_ok_reg;
        acc_next       = acc_reg;
        closed_next    = closed_reg;
        bad_next       = bad_reg;
        offset_next    = offset_reg;
        start_next     = start_reg;
        res_valid      = 1'b0;
        res_beat       = '0;

        case (phase_reg)
            PH_ESC: begin
                escape_ok_next = 1'b0;
                acc_next       = '0;
                closed_next    = 1'b0;
                bad_next       = 1'b0;
                offset_next    = '0;
                start_next     = base_ext[POSITION_WIDTH-1:0];
                if (core_beat.last_byte) begin
                    res_valid       = 1'b1;
                    res_beat.status = ST_INCOMPLETE;
                end else begin
                    escape_ok_next = (b == CH_ESC);
                    offset_next    = POSITION_WIDTH'(1);
                    phase_next     = PH_BRACKET;
                end
            end
            PH_BRACKET: begin
                if (!escape_ok_reg || (b != CH_BRACKET)) begin
                    res_valid       = 1'b1;
                    res_beat.status = ST_NOT_CSI;
                    phase_next      = PH_SKIP;
                end else if (core_beat.last_byte) begin
                    res_valid       = 1'b1;
                    res_beat.status = ST_INCOMPLETE;
                end else begin
                    phase_next = PH_PARAMS;
                end
                offset_next = offset_reg + POSITION_WIDTH'(1);
            end
            PH_PARAMS: begin
                if (b inside {[FINAL_LO:FINAL_HI]}) begin
                    res_valid               = 1'b1;
                    res_beat.status         = ST_COMPLETE;
                    res_beat.command_byte   = b;
                    res_beat.mode_value     = present ? acc_reg : 16'd0;
                    res_beat.mode_present   = present;
                    res_beat.start_position = start_ext[15:0];
                    res_beat.end_position   = end_ext[15:0];
                    res_beat.erase_request  = present
                                            && ((b == CH_ERASE_K) || (b == CH_ERASE_J));
                    phase_next              = PH_SKIP;
                end else begin
                    if (!closed_reg && !bad_reg) begin
                        if (b inside {[CH_ZERO:CH_NINE]}) begin
                            acc_next = (acc_sum[19:16] != 4'd0) ? MODE_MAX : acc_sum[15:0];
                        end else if (b inside {CH_SEMI, CH_COLON, CH_NUL}) begin
                            closed_next = 1'b1;
                        end else begin
                            bad_next = 1'b1;
                        end
                    end
                    if (core_beat.last_byte) begin
                        res_valid       = 1'b1;
                        res_beat.status = ST_INCOMPLETE;
                    end
                end
                offset_next = offset_reg + POSITION_WIDTH'(1);
            end
            PH_SKIP: begin
                phase_next = PH_SKIP;
            end
            default: begin
                phase_next = PH_ESC;
            end
        endcase

        if (core_beat.last_byte) begin
            phase_next = PH_ESC;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            phase_reg     <= PH_ESC;
            escape_ok_reg <= 1'b0;
            acc_reg       <= '0;
            closed_reg    <= 1'b0;
            bad_reg       <= 1'b0;
            offset_reg    <= '0;
            start_reg     <= '0;
            m_valid_reg   <= 1'b0;
        end else begin
            if (core_fire) begin
                phase_reg     <= phase_next;
                escape_ok_reg <= escape_ok_next;
                acc_reg       <= acc_next;
                closed_reg    <= closed_next;
                bad_reg       <= bad_next;
                offset_reg    <= offset_next;
                start_reg     <= start_next;
                m_valid_reg   <= res_valid;
            end else if (m_ready) begin
                m_valid_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (core_fire && res_valid) begin
            m_beat_reg <= res_beat;
        end
    end

    `CSIESP_ASSERT_SAME(a_erase_needs_mode, m_valid && m_beat.erase_request,
        m_beat.mode_present, "erase request without a well formed mode")
    `CSIESP_ASSERT_SAME(a_short_result_clear,
        m_valid && (m_beat.status != ST_COMPLETE),
        (m_beat.mode_present == 1'b0) && (m_beat.end_position == 16'd0),
        "incomplete or not-CSI result carries fields")
    `CSIESP_ASSERT_NEXT(a_last_rearms, core_fire && core_beat.last_byte,
        phase_reg == PH_ESC, "last beat did not rearm the parser")
    `CSIESP_ASSERT_NEXT(a_esc_advances,
        core_fire && (phase_reg == PH_ESC) && !core_beat.last_byte,
        phase_reg == PH_BRACKET, "first beat did not advance to bracket check")

endmodule

`default_nettype wire
